[design/uigfc_pkg.sv]
// ----------------------------------------------------------------------------
// uigfc_pkg
// Shared types and constants of the idle-gap frame collector.
// ----------------------------------------------------------------------------
package uigfc_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 8;
  localparam logic [15:0] TIMEOUT_RESET = 16'd8;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    PHASE_IDLE        = 2'd0,
    PHASE_RECEIVING   = 2'd1,
    PHASE_INTERRUPTED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_FETCH,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic take;
    logic fetch;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic complete;
    logic last;
    logic out_free;
  } ctrl_status_t;

endpackage

[design/uigfc_controller.sv]
// ----------------------------------------------------------------------------
// uigfc_controller
// Sequencer: takes items, then walks the frame buffer out one byte at a time.
// ----------------------------------------------------------------------------
module uigfc_controller (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  uigfc_pkg::ctrl_status_t status,
  output uigfc_pkg::ctrl_cmd_t    cmd
);

  uigfc_pkg::state_t state;
  uigfc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uigfc_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      uigfc_pkg::ST_ACCEPT: begin
        if (item_valid && status.complete) begin
          state_next = uigfc_pkg::ST_FETCH;
        end
      end
      uigfc_pkg::ST_FETCH: begin
        state_next = uigfc_pkg::ST_LOAD;
      end
      uigfc_pkg::ST_LOAD: begin
        if (status.out_free) begin
          state_next = status.last ? uigfc_pkg::ST_ACCEPT : uigfc_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = uigfc_pkg::ST_ACCEPT;
      end
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    cmd        = '0;
    case (state)
      uigfc_pkg::ST_ACCEPT: begin
        item_stall = 1'b0;
        cmd.take   = item_valid;
      end
      uigfc_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      uigfc_pkg::ST_LOAD: begin
        cmd.load = status.out_free;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  a_fetch_then_load: assert property (@(posedge clk) disable iff (rst)
    state == uigfc_pkg::ST_FETCH |=> state == uigfc_pkg::ST_LOAD)
    else $error("fetch not followed by load");

  a_complete_starts_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.take && status.complete |=> state == uigfc_pkg::ST_FETCH)
    else $error("completed frame did not start emission");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.load && status.last |=> state == uigfc_pkg::ST_ACCEPT)
    else $error("last byte did not return to accept");

  a_no_take_while_emitting: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !cmd.fetch && !cmd.load && !item_stall)
    else $error("item taken during emission");

endmodule

[design/uigfc_datapath.sv]
// ----------------------------------------------------------------------------
// uigfc_datapath
// Frame buffer, tick counter, phase, fill count and the result register.
// ----------------------------------------------------------------------------
module uigfc_datapath #(
  parameter int BUFFER_DEPTH = uigfc_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [15:0]             cfg_data,
  input  logic                    item_cmd,
  input  logic [7:0]              rx_byte,
  input  uigfc_pkg::ctrl_cmd_t    cmd,
  output uigfc_pkg::ctrl_status_t status,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [7:0]              frame_byte,
  output logic [2:0]              byte_position,
  output logic                    is_last
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]        mem [BUFFER_DEPTH];
  logic [7:0]        rd_data;
  logic [15:0]       timeout_ticks;
  logic [15:0]       tick_count;
  logic [15:0]       tick_inc;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  emit_cnt;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_addr;
  uigfc_pkg::phase_t phase;
  logic              expire;
  logic              full;
  logic              is_byte;

  assign is_byte  = (item_cmd == uigfc_pkg::CMD_BYTE);
  assign tick_inc = tick_count + 16'd1;
  assign expire   = (tick_inc >= timeout_ticks);
  assign full     = (fill_count == CNT_W'(BUFFER_DEPTH));
  assign wr_addr  = full ? '0 : fill_count[IDX_W-1:0];

  assign status.complete = !is_byte && expire && (phase == uigfc_pkg::PHASE_INTERRUPTED)
                           && (fill_count != '0);
  assign status.last     = ((CNT_W'(rd_idx) + CNT_W'(1)) == emit_cnt);
  assign status.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= uigfc_pkg::TIMEOUT_RESET;
      tick_count    <= '0;
      fill_count    <= '0;
      phase         <= uigfc_pkg::PHASE_IDLE;
      emit_cnt      <= '0;
      rd_idx        <= '0;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      if (cmd.take) begin
        if (is_byte) begin
          fill_count <= full ? CNT_W'(1) : fill_count + CNT_W'(1);
          phase      <= uigfc_pkg::PHASE_RECEIVING;
        end else begin
          tick_count <= expire ? '0 : tick_inc;
          if (expire) begin
            case (phase)
              uigfc_pkg::PHASE_RECEIVING: begin
                phase <= uigfc_pkg::PHASE_INTERRUPTED;
              end
              uigfc_pkg::PHASE_INTERRUPTED: begin
                fill_count <= '0;
                phase      <= uigfc_pkg::PHASE_IDLE;
                emit_cnt   <= fill_count;
                rd_idx     <= '0;
              end
              default: begin
                phase <= phase;
              end
            endcase
          end
        end
      end
      if (cmd.load && !status.last) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_byte) begin
      mem[wr_addr] <= rx_byte;
    end
    if (cmd.fetch) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_byte    <= rd_data;
      byte_position <= 3'(rd_idx);
      is_last       <= status.last;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> status.out_free)
    else $error("result register overwritten");

  a_idx_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !status.last |=> rd_idx == $past(rd_idx) + IDX_W'(1))
    else $error("read index did not advance");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.take && is_byte |=> fill_count != '0 && fill_count <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count out of range");

endmodule

[design/uart_idle_gap_frame_collector.sv]
// ----------------------------------------------------------------------------
// uart_idle_gap_frame_collector
// Collects serial bytes into a frame and releases it after an idle gap.
//
// Item channel (item_valid/item_stall): cmd 0 carries a received byte in
// rx_byte, cmd 1 is a one-millisecond tick. Items are taken while item_stall is low.
// A tick counter expires every timeout_ticks ticks; the second expiry after
// the last byte completes the frame. Result channel (result_valid/
// result_stall) then carries the frame bytes in order with byte_position
// and is_last on the final one.
// Emission: each byte takes a frame-buffer read (FETCH state) and then a
// result register load (LOAD state); while a frame is emitted, item_stall
// is high. A stalled result holds and pauses the emission.
// cfg_write loads timeout_ticks (reset 8); the user must do so only while
// the block is idle, as the block itself does not enforce this.
// Reset clears phase, fill count, tick counter and the result valid; the
// frame buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_idle_gap_frame_collector #(
  parameter int BUFFER_DEPTH = uigfc_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  frame_byte,
  output logic [2:0]  byte_position,
  output logic        is_last
);

  uigfc_pkg::ctrl_cmd_t    ctrl_cmd;
  uigfc_pkg::ctrl_status_t ctrl_status;

  uigfc_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (ctrl_status),
    .cmd        (ctrl_cmd)
  );

  uigfc_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .item_cmd      (cmd),
    .rx_byte       (rx_byte),
    .cmd           (ctrl_cmd),
    .status        (ctrl_status),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .is_last       (is_last)
  );

endmodule
